FILE: hw/rtl/wsd_pkg.sv
// Shared types, codes and helpers for the WebSocket frame deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4
    } wsd_phase_t;

    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [2:0] ACT_TEXT      = 3'd0;
    localparam logic [2:0] ACT_CLOSE     = 3'd1;
    localparam logic [2:0] ACT_PING      = 3'd2;
    localparam logic [2:0] ACT_PONG      = 3'd3;
    localparam logic [2:0] ACT_UNHANDLED = 3'd4;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [2:0] EXT16_CNT = 3'd1;
    localparam logic [2:0] EXT64_CNT = 3'd7;
    localparam logic [2:0] KEY_CNT   = 3'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic       has_data;
        logic [7:0] raw;
        logic [7:0] key_byte;
        logic [3:0] opcode;
        logic       last;
    } wsd_entry_t;

    typedef struct packed {
        logic       valid;
        wsd_entry_t entry;
    } wsd_push_t;

    function automatic logic [2:0] action_of(input logic [3:0] op);
        logic [2:0] act;
        case (op)
            OP_TEXT:  act = ACT_TEXT;
            OP_CLOSE: act = ACT_CLOSE;
            OP_PING:  act = ACT_PING;
            OP_PONG:  act = ACT_PONG;
            default:  act = ACT_UNHANDLED;
        endcase
        return act;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/wsd_front.sv
// Header parser: accepts stream bytes, tracks frame phase and length,
// and pushes payload/marker entries into the queue. Uses wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_front #(
    parameter int LENGTH_BITS = 64
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [7:0]          s_tdata,
    input  wire                 q_full,
    output wsd_pkg::wsd_push_t  push
);
    import wsd_pkg::*;

    wsd_phase_t             phase_reg, phase_next;
    logic [3:0]             opcode_reg, opcode_next;
    logic                   mask_reg, mask_next;
    logic [2:0]             cnt_reg, cnt_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic [31:0]            key_reg, key_next;
    logic [1:0]             pos_reg, pos_next;

    logic                   acc;
    logic [6:0]             len7;
    logic                   len_ext;
    logic [LENGTH_BITS-1:0] len7_ext;
    logic [LENGTH_BITS-1:0] ext_rem;
    logic                   cnt_zero;
    logic                   rem_one;
    logic [7:0]             key_sel;

    assign s_tready = !q_full;
    assign acc      = s_tvalid && s_tready;
    assign len7     = s_tdata[6:0];
    assign len_ext  = (len7 == LEN_EXT16) || (len7 == LEN_EXT64);
    assign len7_ext = {{(LENGTH_BITS-7){1'b0}}, len7};
    assign ext_rem  = {rem_reg[LENGTH_BITS-9:0], s_tdata};
    assign cnt_zero = (cnt_reg == 3'd0);
    assign rem_one  = (rem_reg == LENGTH_BITS'(1));
    assign key_sel  = 8'(key_reg >> {~pos_reg, 3'b000});

    always_comb
    begin
        phase_next = phase_reg;
        if (acc)
        begin
            case (phase_reg)
                PH_HDR1:
                begin
                    if (len_ext)
                        phase_next = PH_EXT;
                    else if (s_tdata[7])
                        phase_next = PH_KEY;
                    else if (len7 == 7'd0)
                        phase_next = PH_HDR0;
                    else
                        phase_next = PH_DATA;
                end
                PH_EXT:
                begin
                    if (!cnt_zero)
                        phase_next = PH_EXT;
                    else if (mask_reg)
                        phase_next = PH_KEY;
                    else if (ext_rem == '0)
                        phase_next = PH_HDR0;
                    else
                        phase_next = PH_DATA;
                end
                PH_KEY:
                begin
                    if (!cnt_zero)
                        phase_next = PH_KEY;
                    else if (rem_reg == '0)
                        phase_next = PH_HDR0;
                    else
                        phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    phase_next = rem_one ? PH_HDR0 : PH_DATA;
                end
                default:
                begin
                    phase_next = PH_HDR1;
                end
            endcase
        end
    end

    always_comb
    begin
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        push        = '0;
        push.entry.opcode = opcode_reg;
        push.entry.last   = 1'b1;
        if (acc)
        begin
            case (phase_reg)
                PH_HDR1:
                begin
                    mask_next = s_tdata[7];
                    key_next  = '0;
                    rem_next  = '0;
                    if (len7 == LEN_EXT16)
                        cnt_next = EXT16_CNT;
                    else if (len7 == LEN_EXT64)
                        cnt_next = EXT64_CNT;
                    else
                    begin
                        rem_next = len7_ext;
                        if (s_tdata[7])
                            cnt_next = KEY_CNT;
                        else
                        begin
                            pos_next   = 2'd0;
                            push.valid = (len7 == 7'd0);
                        end
                    end
                end
                PH_EXT:
                begin
                    rem_next = ext_rem;
                    if (!cnt_zero)
                        cnt_next = cnt_reg - 3'd1;
                    else if (mask_reg)
                        cnt_next = KEY_CNT;
                    else
                    begin
                        pos_next   = 2'd0;
                        push.valid = (ext_rem == '0);
                    end
                end
                PH_KEY:
                begin
                    key_next = {key_reg[23:0], s_tdata};
                    if (!cnt_zero)
                        cnt_next = cnt_reg - 3'd1;
                    else
                    begin
                        pos_next   = 2'd0;
                        push.valid = (rem_reg == '0);
                    end
                end
                PH_DATA:
                begin
                    pos_next = pos_reg + 2'd1;
                    rem_next = rem_reg - LENGTH_BITS'(1);
                    push.valid          = 1'b1;
                    push.entry.has_data = 1'b1;
                    push.entry.raw      = s_tdata;
                    push.entry.key_byte = mask_reg ? key_sel : 8'd0;
                    push.entry.last     = rem_one;
                end
                default:
                begin
                    opcode_next = s_tdata[3:0];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            opcode_reg <= '0;
            mask_reg   <= 1'b0;
            cnt_reg    <= '0;
            rem_reg    <= '0;
            key_reg    <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            mask_reg   <= mask_next;
            cnt_reg    <= cnt_next;
            rem_reg    <= rem_next;
            key_reg    <= key_next;
            pos_reg    <= pos_next;
        end
    end

    a_data_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> rem_reg != '0)
        else $error("payload phase with zero remaining length");

    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> acc && !q_full)
        else $error("queue push without an accepted beat");

    a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid && !push.entry.has_data |->
            push.entry.last && push.entry.raw == 8'd0 && push.entry.key_byte == 8'd0)
        else $error("malformed empty-frame marker");

endmodule

`default_nettype wire

FILE: hw/rtl/wsd_queue.sv
// Short FIFO of parsed entries between the header parser and the output stage.
// Uses wsd_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module wsd_queue (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wsd_pkg::wsd_push_t   push,
    output logic                 full,
    input  wire                  pop,
    output logic                 empty,
    output wsd_pkg::wsd_entry_t  head
);
    import wsd_pkg::*;

    wsd_entry_t            mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full    = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (QUEUE_AW+1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (QUEUE_AW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push.entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/wsd_back.sv
// Output stage: unmasks queued bytes, decodes the dispatch action and holds
// the result beat in a register for the master side. Uses wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_back (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  q_empty,
    input  wsd_pkg::wsd_entry_t  head,
    output logic                 pop,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [15:0]          m_tdata,   // payload_byte[7:0], frame_opcode[11:8],
                                            // action[14:12], pad[15]
    output logic                 m_tuser,   // has_data
    output logic                 m_tlast
);
    import wsd_pkg::*;

    logic        tvalid_reg, tvalid_next;
    logic [15:0] tdata_reg, tdata_next;
    logic        tuser_reg, tuser_next;
    logic        tlast_reg, tlast_next;
    logic        load;

    assign load = !tvalid_reg || m_tready;
    assign pop  = load && !q_empty;

    always_comb
    begin
        tvalid_next = tvalid_reg;
        tdata_next  = tdata_reg;
        tuser_next  = tuser_reg;
        tlast_next  = tlast_reg;
        if (pop)
        begin
            tvalid_next = 1'b1;
            tdata_next  = {1'b0, action_of(head.opcode), head.opcode,
                           head.raw ^ head.key_byte};
            tuser_next  = head.has_data;
            tlast_next  = head.last;
        end
        else if (m_tready)
        begin
            tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tvalid_reg <= 1'b0;
        else
            tvalid_reg <= tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        tdata_reg <= tdata_next;
        tuser_reg <= tuser_next;
        tlast_reg <= tlast_next;
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/websocket_frame_deframer.sv
// WebSocket frame deframer top level: header parser, entry queue, output stage.
// Accepts one byte per cycle while the 4-entry queue has room; a payload byte or
// empty-frame marker is written into the queue, then loaded into the output register.
// Sustained rate is one beat per cycle in and out while m_tready stays high.
// rst_n is asynchronous, active low: parser waits for a first header byte, queue
// and output register are emptied.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer #(
    parameter int LENGTH_BITS = 64
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // rx_byte[7:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // payload_byte[7:0], frame_opcode[11:8],
                                   // action[14:12], pad[15]
    output logic        m_tuser,   // has_data
    output logic        m_tlast
);
    import wsd_pkg::*;

    wsd_push_t  push;
    wsd_entry_t head;
    logic       q_full;
    logic       q_empty;
    logic       pop;

    wsd_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push)
    );

    wsd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .pop   (pop),
        .empty (q_empty),
        .head  (head)
    );

    wsd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: tb/tb_websocket_frame_deframer.sv
// Self-checking testbench for websocket_frame_deframer: a directed frame table, then random
// frames, checked beat by beat against a parser model kept in the bench.
// Depends on wsd_pkg and the websocket_frame_deframer RTL.
`timescale 1ns / 1ps

module tb_websocket_frame_deframer;
    import wsd_pkg::*;

    localparam int LENGTH_BITS = 64;
    localparam int RX_BYTES    = 1900;
    localparam int CALM_TAIL   = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [3:0] OP_CONT = 4'h0;

    typedef struct packed {
        logic       has_data;
        logic [7:0] payload;
        logic [3:0] opcode;
        logic [2:0] act;
        logic       last_beat;
    } deframed_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        deframed_t  want;
    } vector_t;

    localparam deframed_t NO_WANT = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // parser model state
    wsd_phase_t         ph;
    logic [3:0]         op_q;
    logic               masked;
    logic [2:0]         cnt;
    logic [63:0]        remain;
    logic [31:0]        key;
    logic [1:0]         pos;

    deframed_t deframed_q[$];
    vector_t   vectors [0:26];
    int        errors = 0;
    int        sent = 0;
    int        cycles = 0;
    int        stall_left = 0;
    logic      quiet = 1'b0;
    logic      calm = 1'b0;

    websocket_frame_deframer #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic parse_rx_byte(input logic [7:0] rx, output deframed_t res);
        logic [7:0] b;
        logic       len_end;
        logic       hdr_end;
        logic       hit;
        b = rx;
        len_end = 1'b0;
        hdr_end = 1'b0;
        hit = 1'b0;
        res = '0;
        case (ph)
            PH_HDR1:
            begin
                masked = b[7];
                remain = '0;
                key = '0;
                if (b[6:0] == LEN_EXT16)
                begin
                    ph = PH_EXT;
                    cnt = EXT16_CNT;
                end
                else if (b[6:0] == LEN_EXT64)
                begin
                    ph = PH_EXT;
                    cnt = EXT64_CNT;
                end
                else
                begin
                    remain = 64'(b[6:0]);
                    len_end = 1'b1;
                end
            end
            PH_EXT:
            begin
                remain = {remain[55:0], b};
                if (cnt != 3'd0)
                    cnt = cnt - 3'd1;
                else
                    len_end = 1'b1;
            end
            PH_KEY:
            begin
                key = {key[23:0], b};
                if (cnt != 3'd0)
                    cnt = cnt - 3'd1;
                else
                    hdr_end = 1'b1;
            end
            PH_DATA:
            begin
                if (masked)
                    b = b ^ key[31 - 8 * pos -: 8];
                pos = pos + 2'd1;
                remain = remain - 64'd1;
                hit = 1'b1;
                res.has_data = 1'b1;
                res.payload = b;
                res.last_beat = (remain == 64'd0);
                if (remain == 64'd0)
                    ph = PH_HDR0;
            end
            default:
            begin
                op_q = b[3:0];
                ph = PH_HDR1;
            end
        endcase
        if (len_end)
        begin
            if (masked)
            begin
                ph = PH_KEY;
                cnt = KEY_CNT;
            end
            else
                hdr_end = 1'b1;
        end
        // header done: zero length gives the empty-frame marker
        if (hdr_end)
        begin
            pos = 2'd0;
            if (remain == 64'd0)
            begin
                ph = PH_HDR0;
                hit = 1'b1;
                res.last_beat = 1'b1;
            end
            else
                ph = PH_DATA;
        end
        if (hit)
        begin
            res.opcode = op_q;
            case (op_q)
                OP_TEXT:  res.act = ACT_TEXT;
                OP_CLOSE: res.act = ACT_CLOSE;
                OP_PING:  res.act = ACT_PING;
                OP_PONG:  res.act = ACT_PONG;
                default:  res.act = ACT_UNHANDLED;
            endcase
        end
        return hit;
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic typed, input deframed_t want);
        deframed_t got;
        logic      hit;
        if (!quiet && !calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do
            @(posedge clk);
        while (!s_tready);
        hit = parse_rx_byte(b, got);
        if (typed)
            deframed_q.push_back(want);
        else if (hit)
            deframed_q.push_back(got);
        sent++;
    endtask

    // mostly well-formed frames; random opcodes, RSV bits and non-minimal lengths as noise
    task automatic random_frame();
        logic [7:0]  h0;
        logic        m;
        logic [63:0] len;
        logic [6:0]  len7;
        int          kind;
        h0 = 8'($urandom);
        case ($urandom_range(0, 5))
            0: h0[3:0] = OP_TEXT;
            1: h0[3:0] = OP_CLOSE;
            2: h0[3:0] = OP_PING;
            3: h0[3:0] = OP_PONG;
            default: ;
        endcase
        m = 1'($urandom);
        kind = $urandom_range(0, 9);
        case (kind)
            6:
            begin
                len = 64'($urandom_range(100, 125));
                len7 = len[6:0];
            end
            7:
            begin
                len = 64'($urandom_range(0, 300));
                len7 = LEN_EXT16;
            end
            8:
            begin
                len = 64'($urandom_range(0, 20));
                len7 = LEN_EXT64;
            end
            9:
            begin
                len = 64'($urandom_range(0, 4));
                len7 = LEN_EXT16;
            end
            default:
            begin
                len = 64'($urandom_range(0, 12));
                len7 = len[6:0];
            end
        endcase
        calm = ($urandom_range(0, 4) == 0);
        put_byte(h0, 1'b0, NO_WANT);
        put_byte({m, len7}, 1'b0, NO_WANT);
        if (len7 == LEN_EXT16)
        begin
            put_byte(len[15:8], 1'b0, NO_WANT);
            put_byte(len[7:0], 1'b0, NO_WANT);
        end
        else if (len7 == LEN_EXT64)
        begin
            for (int i = 7; i >= 0; i--)
                put_byte(len[8 * i +: 8], 1'b0, NO_WANT);
        end
        if (m)
        begin
            repeat (4) put_byte(8'($urandom), 1'b0, NO_WANT);
        end
        for (int i = 0; i < int'(len); i++)
            put_byte(8'($urandom), 1'b0, NO_WANT);
        calm = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_beats
        deframed_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (deframed_q.size() == 0)
            begin
                $error("unexpected beat: tdata %0h tuser %0b tlast %0b",
                       m_tdata, m_tuser, m_tlast);
                errors++;
            end
            else
            begin
                want = deframed_q.pop_front();
                if (m_tuser !== want.has_data)
                begin
                    $error("has_data: expected %0h, got %0h", want.has_data, m_tuser);
                    errors++;
                end
                if (m_tdata[7:0] !== want.payload)
                begin
                    $error("payload_byte: expected %0h, got %0h", want.payload, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[11:8] !== want.opcode)
                begin
                    $error("frame_opcode: expected %0h, got %0h", want.opcode, m_tdata[11:8]);
                    errors++;
                end
                if (m_tdata[14:12] !== want.act)
                begin
                    $error("action: expected %0h, got %0h", want.act, m_tdata[14:12]);
                    errors++;
                end
                if (m_tdata[15] !== 1'b0)
                begin
                    $error("pad: expected 0, got %0h", m_tdata[15]);
                    errors++;
                end
                if (m_tlast !== want.last_beat)
                begin
                    $error("last: expected %0h, got %0h", want.last_beat, m_tlast);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        ph = PH_HDR0;
        op_q = '0;
        masked = 1'b0;
        cnt = '0;
        remain = '0;
        key = '0;
        pos = '0;
        vectors = '{
            // empty text frame
            '{8'h81, 1'b0, NO_WANT},
            '{8'h00, 1'b1, '{1'b0, 8'h00, OP_TEXT, ACT_TEXT, 1'b1}},
            // close, one byte
            '{8'h88, 1'b0, NO_WANT},
            '{8'h01, 1'b0, NO_WANT},
            '{8'hFF, 1'b1, '{1'b1, 8'hFF, OP_CLOSE, ACT_CLOSE, 1'b1}},
            // masked ping, one byte
            '{8'h89, 1'b0, NO_WANT},
            '{8'h81, 1'b0, NO_WANT},
            '{8'hA5, 1'b0, NO_WANT},
            '{8'h5A, 1'b0, NO_WANT},
            '{8'h3C, 1'b0, NO_WANT},
            '{8'hC3, 1'b0, NO_WANT},
            '{8'hFF, 1'b0, NO_WANT},
            // pong, 16-bit length of zero
            '{8'h8A, 1'b0, NO_WANT},
            '{8'h7E, 1'b0, NO_WANT},
            '{8'h00, 1'b0, NO_WANT},
            '{8'h00, 1'b1, '{1'b0, 8'h00, OP_PONG, ACT_PONG, 1'b1}},
            // continuation with RSV bits, 64-bit length of one
            '{8'h70, 1'b0, NO_WANT},
            '{8'h7F, 1'b0, NO_WANT},
            '{8'h00, 1'b0, NO_WANT},
            '{8'h00, 1'b0, NO_WANT},
            '{8'h00, 1'b0, NO_WANT},
            '{8'h00, 1'b0, NO_WANT},
            '{8'h00, 1'b0, NO_WANT},
            '{8'h00, 1'b0, NO_WANT},
            '{8'h00, 1'b0, NO_WANT},
            '{8'h01, 1'b0, NO_WANT},
            '{8'h80, 1'b1, '{1'b1, 8'h80, OP_CONT, ACT_UNHANDLED, 1'b1}}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[i])
            put_byte(vectors[i].rx, vectors[i].typed, vectors[i].want);

        while (sent < RX_BYTES)
        begin
            quiet = (sent > RX_BYTES - CALM_TAIL);
            random_frame();
        end

        s_tvalid <= 1'b0;
        while (deframed_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
